@@ design/plid_pkg.sv @@
package plid_pkg;

	// Default list capacity.
	localparam int DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int CMD_W   = 3;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// One command beat.
	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        position;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] removed_key;
		logic [COUNT_W-1:0]      entry_count;
	} res_t;

	// Update strobes from the decoder to the entry array.
	typedef struct packed {
		logic ins;
		logic del;
	} op_t;

endpackage

@@ design/plid_ctrl.sv @@
module plid_ctrl #(
	parameter int DEPTH = plid_pkg::DEPTH_DEF,
	parameter int LW    = $clog2(DEPTH + 1),
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                      valid,
	input  plid_pkg::cmd_t            req,
	input  logic [LW-1:0]             len,
	output plid_pkg::op_t             op,
	output logic [IW-1:0]             idx,
	output logic [LW-1:0]             len_nxt,
	output logic [plid_pkg::STAT_W-1:0] status
);
	import plid_pkg::*;

	localparam int CMPW = ((LW > POS_W) ? LW : POS_W) + 1;
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

	logic [CMPW-1:0] len_w;
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] idx_w;
	logic            is_ins;
	logic            is_del;

	assign len_w = CMPW'(len);
	assign pos_w = CMPW'(req.position);

	// Decode the command against the current length: status, slot and action.
	always_comb begin
		status = ST_OK;
		idx_w  = '0;
		is_ins = 1'b0;
		is_del = 1'b0;
		unique case (req.command)
			CMD_INS_FRONT, CMD_INS_BACK: begin
				idx_w = (req.command == CMD_INS_FRONT) ? '0 : len_w;
				if (len_w >= DEPTH_C) status = ST_FULL;
				else is_ins = 1'b1;
			end
			CMD_INS_POS: begin
				idx_w = pos_w - CMPW'(1);
				if (len_w == '0) status = ST_EMPTY;
				else if (pos_w == '0 || pos_w > len_w + CMPW'(1)) status = ST_BADPOS;
				else if (len_w >= DEPTH_C) status = ST_FULL;
				else is_ins = 1'b1;
			end
			CMD_DEL_FRONT, CMD_DEL_BACK: begin
				idx_w = (req.command == CMD_DEL_FRONT) ? '0 : len_w - CMPW'(1);
				if (len_w == '0) status = ST_EMPTY;
				else is_del = 1'b1;
			end
			CMD_DEL_POS: begin
				idx_w = pos_w - CMPW'(1);
				if (len_w == '0) status = ST_EMPTY;
				else if (pos_w == '0 || pos_w > len_w) status = ST_BADPOS;
				else is_del = 1'b1;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Gate the actions with the stage valid and work out the new length.
	assign op.ins  = valid & is_ins;
	assign op.del  = valid & is_del;
	assign idx     = idx_w[IW-1:0];
	assign len_nxt = is_ins ? len + LW'(1) : (is_del ? len - LW'(1) : len);

endmodule

@@ design/plid_array.sv @@
module plid_array #(
	parameter int DEPTH = plid_pkg::DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  plid_pkg::op_t                  op,
	input  logic [IW-1:0]                  idx,
	input  logic signed [plid_pkg::KEY_W-1:0] wr_key,
	output logic signed [plid_pkg::KEY_W-1:0] rd_key
);
	import plid_pkg::*;

	logic signed [KEY_W-1:0] ent_q [DEPTH];

	// Key at the addressed slot, taken by a delete.
	assign rd_key = ent_q[idx];

	// Each slot loads from its neighbour, the new key, or holds.
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic signed [KEY_W-1:0] nxt;
		logic signed [KEY_W-1:0] prev_v;
		logic signed [KEY_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = ent_q[i];
		end else begin : g_prev
			assign prev_v = ent_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = ent_q[i];
		end else begin : g_next
			assign next_v = ent_q[i+1];
		end

		always_comb begin
			nxt = ent_q[i];
			if (op.ins) begin
				if (IW'(i) == idx) nxt = wr_key;
				else if (IW'(i) > idx) nxt = prev_v;
			end else if (op.del) begin
				if (IW'(i) >= idx) nxt = next_v;
			end
		end

		always_ff @(posedge clk) begin
			ent_q[i] <= nxt;
		end
	end

endmodule

@@ design/positional_list_insert_delete.sv @@
// A command taken into the command register gives its result, marked by done,
// from the result register. Commands are taken only while busy is low.
// Throughput: one command per cycle; every slot shifts through its own mux, so
// the whole update finishes between the command register and the result register.
// Reset (arst_n low, asynchronous) empties the list, drops pending beats and holds
// busy high through reset and the cycle after release; the receiver cannot stall results.
module positional_list_insert_delete #(
	parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  plid_pkg::cmd_t   req,
	output logic             done,
	output plid_pkg::res_t   result
);
	import plid_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic                    busy_q;
	logic                    valid_s1;
	cmd_t                    req_s1;
	logic [LW-1:0]           length_q;
	logic [LW-1:0]           len_nxt;
	op_t                     op;
	logic [IW-1:0]           idx;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] rd_key;
	logic                    done_q;
	res_t                    result_q;

	// Busy while reset is asserted and in the cycle after reset is released.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b1;
		else busy_q <= 1'b0;
	end
	assign busy = busy_q;

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start & ~busy_q;
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) req_s1 <= req;
	end

	plid_ctrl #(.DEPTH(DEPTH), .LW(LW), .IW(IW)) u_ctrl (
		.valid   (valid_s1),
		.req     (req_s1),
		.len     (length_q),
		.op      (op),
		.idx     (idx),
		.len_nxt (len_nxt),
		.status  (status)
	);

	plid_array #(.DEPTH(DEPTH), .IW(IW)) u_array (
		.clk    (clk),
		.op     (op),
		.idx    (idx),
		.wr_key (req_s1.key),
		.rd_key (rd_key)
	);

	// Entry count follows every accepted command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) length_q <= '0;
		else if (valid_s1) length_q <= len_nxt;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.status      <= status;
			result_q.removed_key <= op.del ? rd_key : '0;
			result_q.entry_count <= COUNT_W'(len_nxt);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks on the list control.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("command beat produced no result beat");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LW'(DEPTH))
		else $error("entry count beyond capacity");

	a_op_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.ins && op.del))
		else $error("insert and delete in the same cycle");

	a_err_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != ST_OK) |-> (result_q.removed_key == '0))
		else $error("removed key reported on a failed command");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> (result_q.entry_count == COUNT_W'(length_q)))
		else $error("reported count differs from the stored length");

endmodule
